### sv/binary_trie_max_xor_assert.svh
// Assertion macros for the max-XOR trie block.
`ifndef BINARY_TRIE_MAX_XOR_ASSERT_SVH
`define BINARY_TRIE_MAX_XOR_ASSERT_SVH

// Same-cycle implication.
`define BTMX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BTMX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/btmx_pkg.sv
package btmx_pkg;

   localparam int KEY_BITS   = 31;
   localparam int POOL_NODES = 65536;
   localparam int NODE_BITS  = $clog2(POOL_NODES);
   localparam int FREE_BITS  = $clog2(POOL_NODES + 1);
   localparam int LINK_BITS  = 2 * NODE_BITS;
   localparam int COUNT_BITS = 32;
   localparam int LEVEL_BITS = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam int MISS_BITS  = $clog2(KEY_BITS + 1);

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_QUERY  = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_ABSENT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_TAIL,
      ST_DECIDE,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      PH_CHECK,
      PH_UPDATE,
      PH_QUERY
   } phase_type;

   typedef struct packed {
      logic [NODE_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [NODE_BITS-1:0] wr_addr;
      logic [LINK_BITS-1:0] wr_data;
   } link_req_type;

   typedef struct packed {
      logic [NODE_BITS-1:0]  rd_addr;
      logic                  wr_en;
      logic [NODE_BITS-1:0]  wr_addr;
      logic [COUNT_BITS-1:0] wr_data;
   } count_req_type;

   typedef struct packed {
      logic load;
      logic step;
      logic restart;
      logic push;
   } digit_ctrl_type;

   typedef struct packed {
      logic key_bit;
      logic last;
   } digit_stat_type;

   // links word: child 1 in the upper half, child 0 in the lower half
   function automatic logic [NODE_BITS-1:0] link_get(input logic [LINK_BITS-1:0] links,
                                                     input logic sel);
      return sel ? links[LINK_BITS-1:NODE_BITS] : links[NODE_BITS-1:0];
   endfunction

   function automatic logic [LINK_BITS-1:0] link_set(input logic [LINK_BITS-1:0] links,
                                                     input logic sel,
                                                     input logic [NODE_BITS-1:0] node);
      logic [LINK_BITS-1:0] res;
      res = links;
      if (sel) begin
         res[LINK_BITS-1:NODE_BITS] = node;
      end else begin
         res[NODE_BITS-1:0] = node;
      end
      return res;
   endfunction

endpackage

### sv/btmx_ram.sv
module btmx_ram #(
   parameter int WIDTH     = 32,
   parameter int ADDR_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   localparam int DEPTH = 2 ** ADDR_BITS;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/btmx_digits.sv
module btmx_digits (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [btmx_pkg::KEY_BITS-1:0]   value,
   input  btmx_pkg::digit_ctrl_type        ctrl,
   output btmx_pkg::digit_stat_type        stat,
   output logic [btmx_pkg::KEY_BITS-1:0]   best
);
   import btmx_pkg::*;

   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [KEY_BITS-1:0]   best_ff, best_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;

   // key rotates one bit per level so it is back in place after a full pass
   always_comb begin
      key_in   = key_ff;
      best_in  = best_ff;
      level_in = level_ff;
      if (ctrl.load) begin
         key_in   = value;
         best_in  = '0;
         level_in = LEVEL_BITS'(KEY_BITS - 1);
      end else if (ctrl.restart) begin
         level_in = LEVEL_BITS'(KEY_BITS - 1);
      end else if (ctrl.step) begin
         key_in   = (key_ff << 1) | (key_ff >> (KEY_BITS - 1));
         best_in  = (best_ff << 1) | KEY_BITS'(ctrl.push);
         level_in = level_ff - LEVEL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      best_ff <= best_in;
   end

   assign stat.key_bit = key_ff[KEY_BITS-1];
   assign stat.last    = (level_ff == '0);
   assign best         = best_ff;

endmodule

### sv/btmx_walk.sv
module btmx_walk (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  btmx_pkg::mode_type                mode,
   input  btmx_pkg::digit_stat_type          dstat,
   input  logic [btmx_pkg::LINK_BITS-1:0]    link_rd,
   input  logic [btmx_pkg::COUNT_BITS-1:0]   count_rd,
   output logic                              busy,
   output logic                              rsp_valid,
   output btmx_pkg::status_type              status,
   output btmx_pkg::digit_ctrl_type          dctrl,
   output btmx_pkg::link_req_type            link_req,
   output btmx_pkg::count_req_type           count_req
);
   import btmx_pkg::*;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   mode_type             mode_ff, mode_in;
   status_type           status_ff, status_in;
   logic [NODE_BITS-1:0] cur_ff, cur_in;
   logic                 cur_root_ff, cur_root_in;
   logic                 miss_ff, miss_in;
   logic                 sat_ff, sat_in;
   logic [MISS_BITS-1:0] missing_ff, missing_in;
   logic [FREE_BITS-1:0] next_free_ff, next_free_in;
   logic [LINK_BITS-1:0] root_ff, root_in;
   logic [LINK_BITS-1:0] prev_links_ff, prev_links_in;
   logic                 prev_bit_ff, prev_bit_in;
   logic                 prev_root_ff, prev_root_in;
   logic [NODE_BITS-1:0] prev_node_ff, prev_node_in;

   logic                  key_bit;
   logic                  walking;
   logic [LINK_BITS-1:0]  cur_links;
   logic [NODE_BITS-1:0]  child;
   logic [NODE_BITS-1:0]  opp;
   logic [NODE_BITS-1:0]  alloc;
   logic                  child_ok;
   logic                  take_opp;
   logic                  in_node;
   logic [COUNT_BITS-1:0] count_dec;
   logic                  unlink_stop;
   logic [FREE_BITS:0]    need_sum;
   logic                  refuse;

   // per-level datapath shared by next state and outputs
   always_comb begin
      key_bit   = dstat.key_bit;
      walking   = (state_ff == ST_WALK);
      cur_links = cur_root_ff ? root_ff : link_rd;
      child     = link_get(cur_links, key_bit);
      opp       = link_get(cur_links, !key_bit);
      alloc     = next_free_ff[NODE_BITS-1:0];
      child_ok  = !miss_ff && (child != '0);
      take_opp  = !miss_ff && (opp != '0);
      in_node   = !cur_root_ff && !miss_ff;
      count_dec = count_rd - COUNT_BITS'(1);
      unlink_stop = (phase_ff == PH_UPDATE) && (mode_ff == MODE_REMOVE)
                    && in_node && (count_dec == '0);
      need_sum  = {1'b0, next_free_ff} + (FREE_BITS + 1)'(missing_ff);
      if (mode_ff == MODE_INSERT) begin
         refuse = sat_ff || (need_sum > (FREE_BITS + 1)'(POOL_NODES));
      end else begin
         refuse = miss_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (mode == MODE_NOP) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (unlink_stop) begin
               state_in = ST_RESP;
            end else if (dstat.last) begin
               state_in = (phase_ff == PH_QUERY) ? ST_RESP : ST_TAIL;
            end
         end
         ST_TAIL:   state_in = (phase_ff == PH_CHECK) ? ST_DECIDE : ST_RESP;
         ST_DECIDE: state_in = refuse ? ST_RESP : ST_WALK;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      mode_in       = mode_ff;
      status_in     = status_ff;
      cur_in        = cur_ff;
      cur_root_in   = cur_root_ff;
      miss_in       = miss_ff;
      sat_in        = sat_ff;
      missing_in    = missing_ff;
      next_free_in  = next_free_ff;
      root_in       = root_ff;
      prev_links_in = prev_links_ff;
      prev_bit_in   = prev_bit_ff;
      prev_root_in  = prev_root_ff;
      prev_node_in  = prev_node_ff;
      dctrl         = '0;
      link_req      = '0;
      count_req     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in     = mode;
               phase_in    = (mode == MODE_QUERY) ? PH_QUERY : PH_CHECK;
               cur_in      = '0;
               cur_root_in = 1'b1;
               miss_in     = 1'b0;
               sat_in      = 1'b0;
               missing_in  = '0;
               status_in   = STATUS_OK;
               dctrl.load  = 1'b1;
            end
         end
         ST_WALK, ST_TAIL: begin
            dctrl.step = walking;
            unique case (phase_ff)
               PH_CHECK: begin
                  if (mode_ff == MODE_INSERT && in_node && count_rd == '1) begin
                     sat_in = 1'b1;
                  end
                  if (walking) begin
                     cur_in      = child;
                     cur_root_in = 1'b0;
                     // once off the trie every remaining level needs a new node
                     if (!child_ok) begin
                        miss_in    = 1'b1;
                        missing_in = missing_ff + MISS_BITS'(1);
                     end
                  end
               end
               PH_UPDATE: begin
                  if (mode_ff == MODE_INSERT) begin
                     if (!cur_root_ff) begin
                        count_req.wr_en   = 1'b1;
                        count_req.wr_addr = cur_ff;
                        count_req.wr_data = miss_ff ? COUNT_BITS'(1)
                                                    : count_rd + COUNT_BITS'(1);
                     end
                     if (walking) begin
                        cur_root_in = 1'b0;
                        if (child_ok) begin
                           cur_in = child;
                        end else begin
                           cur_in       = alloc;
                           next_free_in = next_free_ff + FREE_BITS'(1);
                           miss_in      = 1'b1;
                           if (cur_root_ff) begin
                              root_in = link_set(root_ff, key_bit, alloc);
                           end else begin
                              link_req.wr_en   = 1'b1;
                              link_req.wr_addr = cur_ff;
                              link_req.wr_data = link_set(miss_ff ? '0 : link_rd,
                                                          key_bit, alloc);
                           end
                        end
                     end
                  end else begin
                     if (in_node) begin
                        count_req.wr_en   = 1'b1;
                        count_req.wr_addr = cur_ff;
                        count_req.wr_data = count_dec;
                        // first node to empty is cut from its parent
                        if (count_dec == '0) begin
                           if (prev_root_ff) begin
                              root_in = link_set(root_ff, prev_bit_ff, '0);
                           end else begin
                              link_req.wr_en   = 1'b1;
                              link_req.wr_addr = prev_node_ff;
                              link_req.wr_data = link_set(prev_links_ff, prev_bit_ff, '0);
                           end
                        end
                     end
                     if (walking) begin
                        prev_links_in = cur_links;
                        prev_bit_in   = key_bit;
                        prev_root_in  = cur_root_ff;
                        prev_node_in  = cur_ff;
                        cur_in        = child;
                        cur_root_in   = 1'b0;
                     end
                  end
               end
               PH_QUERY: begin
                  cur_in      = take_opp ? opp : child;
                  cur_root_in = 1'b0;
                  miss_in     = miss_ff || (!take_opp && child == '0);
                  dctrl.push  = take_opp;
               end
               default: ;
            endcase
         end
         ST_DECIDE: begin
            if (refuse) begin
               status_in = (mode_ff == MODE_INSERT) ? STATUS_FULL : STATUS_ABSENT;
            end else begin
               phase_in      = PH_UPDATE;
               cur_in        = '0;
               cur_root_in   = 1'b1;
               miss_in       = 1'b0;
               dctrl.restart = 1'b1;
            end
         end
         ST_RESP: ;
         default: ;
      endcase

      // memories always read the node the walk moves to next
      link_req.rd_addr  = cur_in;
      count_req.rd_addr = cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_free_ff <= FREE_BITS'(1);
         root_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         next_free_ff <= next_free_in;
         root_ff      <= root_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff      <= phase_in;
      mode_ff       <= mode_in;
      status_ff     <= status_in;
      cur_ff        <= cur_in;
      cur_root_ff   <= cur_root_in;
      miss_ff       <= miss_in;
      sat_ff        <= sat_in;
      missing_ff    <= missing_in;
      prev_links_ff <= prev_links_in;
      prev_bit_ff   <= prev_bit_in;
      prev_root_ff  <= prev_root_in;
      prev_node_ff  <= prev_node_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign status    = status_ff;

endmodule

### sv/binary_trie_max_xor.sv
// Channel   Ports                                   Flow
// request   start, busy, req_mode, req_value        taken when start && !busy
// response  rsp_valid, rsp_best_xor, rsp_status     one-cycle strobe, no back-pressure
//
// One trie level per cycle, set by the registered read of the link memory.
// Query: one walk pass. Insert: check pass, decide, update pass; ends at decide if refused.
// Remove: the same passes; update stops early when a node empties. Mode 3: no walk.
// The block returns to idle after each word before the next is taken.
// Reset empties the pool at once: root links live in flops, nodes are written on
// allocation, so there is no clearing pass. Results cannot be stalled.
module binary_trie_max_xor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_mode,
   input  logic [btmx_pkg::KEY_BITS-1:0]   req_value,
   output logic                            rsp_valid,
   output logic [btmx_pkg::KEY_BITS-1:0]   rsp_best_xor,
   output logic [1:0]                      rsp_status
);
   import btmx_pkg::*;

   digit_ctrl_type        dctrl;
   digit_stat_type        dstat;
   link_req_type          link_req;
   count_req_type         count_req;
   logic [LINK_BITS-1:0]  link_rd;
   logic [COUNT_BITS-1:0] count_rd;
   status_type            status;
   mode_type              mode;

   assign mode = mode_type'(req_mode);

   btmx_ram #(
      .WIDTH     (LINK_BITS),
      .ADDR_BITS (NODE_BITS)
   ) u_links (
      .clock   (clock),
      .wr_en   (link_req.wr_en),
      .wr_addr (link_req.wr_addr),
      .wr_data (link_req.wr_data),
      .rd_addr (link_req.rd_addr),
      .rd_data (link_rd)
   );

   btmx_ram #(
      .WIDTH     (COUNT_BITS),
      .ADDR_BITS (NODE_BITS)
   ) u_counts (
      .clock   (clock),
      .wr_en   (count_req.wr_en),
      .wr_addr (count_req.wr_addr),
      .wr_data (count_req.wr_data),
      .rd_addr (count_req.rd_addr),
      .rd_data (count_rd)
   );

   btmx_digits u_digits (
      .clock (clock),
      .reset (reset),
      .value (req_value),
      .ctrl  (dctrl),
      .stat  (dstat),
      .best  (rsp_best_xor)
   );

   btmx_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .mode      (mode),
      .dstat     (dstat),
      .link_rd   (link_rd),
      .count_rd  (count_rd),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .dctrl     (dctrl),
      .link_req  (link_req),
      .count_req (count_req)
   );

   assign rsp_status = status;

endmodule

### sv/btmx_check.sv
`include "binary_trie_max_xor_assert.svh"

module btmx_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [btmx_pkg::KEY_BITS-1:0]   rsp_best_xor,
   input logic [1:0]                      rsp_status
);
   import btmx_pkg::*;

   `BTMX_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted word did not raise busy")
   `BTMX_ASSERT_NOW(a_rsp_in_busy, clock, reset, rsp_valid, busy, "result outside a busy window")
   `BTMX_ASSERT_NEXT(a_rsp_ends, clock, reset, rsp_valid, !busy && !rsp_valid, "busy held after result")
   `BTMX_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_best_xor == '0, "error result with nonzero best_xor")
   `BTMX_ASSERT_NOW(a_busy_cause, clock, reset, $rose(busy), $past(start), "busy rose without start")

endmodule

bind binary_trie_max_xor btmx_check u_btmx_check (.*);

### test/binary_trie_max_xor_tb.sv
`timescale 1ns / 100ps

module binary_trie_max_xor_tb;
   import btmx_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int SETTLE_CYCLES = 80;
   localparam bit [KEY_BITS-1:0] ONE_KEY = KEY_BITS'(1);

   typedef struct {
      mode_type          mode;
      bit [KEY_BITS-1:0] value;
   } trie_cmd_type;

   typedef struct {
      bit [KEY_BITS-1:0] best_xor;
      status_type        status;
   } trie_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_mode = MODE_NOP;
   logic [KEY_BITS-1:0] req_value = '0;
   logic                rsp_valid;
   logic [KEY_BITS-1:0] rsp_best_xor;
   logic [1:0]          rsp_status;

   // shadow trie: link 0 means absent, node 0 is the root
   bit [NODE_BITS-1:0] trie_kid [POOL_NODES][2];
   bit [31:0]          trie_count [POOL_NODES];
   int unsigned        trie_next_free = 1;

   trie_cmd_type       cmd_queue[$];
   trie_rsp_type       expected_answers[$];
   bit [KEY_BITS-1:0]  held_keys[$];
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   bit                 idling_on = 1'b1;
   int                 idle_left = 0;
   bit                 idle_wait_ready = 1'b0;

   binary_trie_max_xor u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_best_xor (rsp_best_xor),
      .rsp_status   (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic trie_rsp_type apply_to_trie(input mode_type mode,
                                                  input bit [KEY_BITS-1:0] key);
      trie_rsp_type       ans;
      bit [NODE_BITS-1:0] node;
      bit [NODE_BITS-1:0] prev;
      int unsigned        missing;
      bit                 saturated;
      bit                 done;
      bit                 b;
      int                 i;
      ans.best_xor = '0;
      ans.status = STATUS_OK;
      node = '0;
      prev = '0;
      missing = 0;
      saturated = 1'b0;
      done = 1'b0;
      case (mode)
         MODE_INSERT: begin
            // count the nodes the key still lacks before touching anything
            for (i = KEY_BITS - 1; i >= 0; i--) begin
               b = key[i];
               if (missing == 0 && trie_kid[node][b] != 0) begin
                  node = trie_kid[node][b];
                  if (trie_count[node] == 32'hFFFF_FFFF) saturated = 1'b1;
               end else begin
                  missing++;
               end
            end
            if (saturated || trie_next_free + missing > POOL_NODES) begin
               ans.status = STATUS_FULL;
            end else begin
               node = '0;
               for (i = KEY_BITS - 1; i >= 0; i--) begin
                  b = key[i];
                  if (trie_kid[node][b] == 0) begin
                     trie_kid[node][b] = trie_next_free[NODE_BITS-1:0];
                     trie_next_free++;
                  end
                  node = trie_kid[node][b];
                  trie_count[node]++;
               end
            end
         end
         MODE_REMOVE: begin
            for (i = KEY_BITS - 1; i >= 0 && !done; i--) begin
               b = key[i];
               if (trie_kid[node][b] == 0) begin
                  ans.status = STATUS_ABSENT;
                  done = 1'b1;
               end else begin
                  node = trie_kid[node][b];
               end
            end
            if (!done) begin
               // cut the path at the first node that empties; deeper nodes leak
               node = '0;
               for (i = KEY_BITS - 1; i >= 0 && !done; i--) begin
                  b = key[i];
                  node = trie_kid[node][b];
                  trie_count[node]--;
                  if (trie_count[node] == 0) begin
                     trie_kid[prev][b] = '0;
                     done = 1'b1;
                  end
                  prev = node;
               end
            end
         end
         MODE_QUERY: begin
            if (trie_kid[0][0] != 0 || trie_kid[0][1] != 0) begin
               for (i = KEY_BITS - 1; i >= 0; i--) begin
                  b = key[i];
                  if (trie_kid[node][b ^ 1'b1] != 0) begin
                     ans.best_xor[i] = 1'b1;
                     node = trie_kid[node][b ^ 1'b1];
                  end else begin
                     node = trie_kid[node][b];
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // driver: a word is taken when start && !busy at the edge
   always @(posedge clock) begin : drive_blk
      trie_cmd_type w;
      if (reset) begin
         start <= 1'b0;
         idle_left <= 0;
      end else begin
         if (start && !busy) begin
            expected_answers.push_back(apply_to_trie(mode_type'(req_mode), req_value));
         end
         if (!start || !busy) begin
            if (idle_left > 0) begin
               // some bursts count from the take, some only once the block is free
               if (!idle_wait_ready || !busy) idle_left <= idle_left - 1;
               start <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
               w = cmd_queue.pop_front();
               start <= 1'b1;
               req_mode <= w.mode;
               req_value <= w.value;
               if (idling_on && $urandom_range(0, 3) == 0) begin
                  idle_left <= $urandom_range(1, 13);
                  idle_wait_ready <= 1'($urandom_range(0, 1));
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_blk
      trie_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_answers.size() == 0) begin
            report_mismatch($sformatf("word with nothing pending: best_xor %h status %0d",
                                      rsp_best_xor, rsp_status));
         end else begin
            want = expected_answers.pop_front();
            if (rsp_best_xor !== want.best_xor) begin
               report_mismatch($sformatf("best_xor got %h want %h", rsp_best_xor,
                                         want.best_xor));
            end
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("status got %0d want %0d", rsp_status,
                                         want.status));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic bit [KEY_BITS-1:0] rand_key();
      bit [31:0] r;
      r = $urandom();
      return r[KEY_BITS-1:0];
   endfunction

   function automatic bit [KEY_BITS-1:0] pick_key();
      bit [KEY_BITS-1:0] k;
      k = rand_key();
      case ($urandom_range(0, 5))
         0: k = KEY_BITS'($urandom_range(0, 63));
         1: k = {KEY_BITS{1'b1}} - KEY_BITS'($urandom_range(0, 63));
         2: begin
            // near miss of a stored key: one random bit flipped
            if (held_keys.size() > 0) begin
               k = held_keys[$urandom_range(0, held_keys.size() - 1)] ^
                   (ONE_KEY << $urandom_range(0, KEY_BITS - 1));
            end
         end
         3: k = ONE_KEY << $urandom_range(0, KEY_BITS - 1);
         4: begin
            if (held_keys.size() > 0) k = held_keys[$urandom_range(0, held_keys.size() - 1)];
         end
         default: begin
         end
      endcase
      return k;
   endfunction

   task automatic push_cmd(input mode_type m, input bit [KEY_BITS-1:0] k);
      trie_cmd_type c;
      c.mode = m;
      c.value = k;
      cmd_queue.push_back(c);
   endtask

   task automatic wait_for_drain();
      while (cmd_queue.size() != 0 || start || expected_answers.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin : stimulus
      int chunk;
      int n;
      int r;
      int idx;
      bit [KEY_BITS-1:0] v;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty trie, extremes, duplicates, unlinking, absent keys
      push_cmd(MODE_QUERY, 31'h1234_5678);
      push_cmd(MODE_REMOVE, 31'h0);
      push_cmd(MODE_NOP, 31'h7FFF_FFFF);
      push_cmd(MODE_INSERT, 31'h0);
      push_cmd(MODE_QUERY, 31'h0);
      push_cmd(MODE_QUERY, 31'h7FFF_FFFF);
      push_cmd(MODE_INSERT, 31'h7FFF_FFFF);
      push_cmd(MODE_QUERY, 31'h2AAA_AAAA);
      push_cmd(MODE_INSERT, 31'h0);
      push_cmd(MODE_REMOVE, 31'h0);
      push_cmd(MODE_QUERY, 31'h7FFF_FFFF);
      push_cmd(MODE_REMOVE, 31'h0);
      push_cmd(MODE_REMOVE, 31'h0);
      push_cmd(MODE_REMOVE, 31'h7FFF_FFFE);
      push_cmd(MODE_QUERY, 31'h7FFF_FFFF);
      push_cmd(MODE_INSERT, 31'h4000_0000);
      push_cmd(MODE_INSERT, 31'h3FFF_FFFF);
      push_cmd(MODE_QUERY, 31'h4000_0000);
      push_cmd(MODE_NOP, 31'h0);
      push_cmd(MODE_REMOVE, 31'h7FFF_FFFF);
      push_cmd(MODE_REMOVE, 31'h4000_0000);
      push_cmd(MODE_REMOVE, 31'h3FFF_FFFF);
      push_cmd(MODE_QUERY, 31'h5555_5555);
      push_cmd(MODE_REMOVE, 31'h3FFF_FFFF);
      wait_for_drain();

      // random mix; the sender waits for every answer between chunks
      for (chunk = 0; chunk < 9; chunk++) begin
         idling_on = (chunk % 3) != 2;
         for (n = 0; n < 200; n++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
               v = pick_key();
               push_cmd(MODE_INSERT, v);
               held_keys.push_back(v);
            end else if (r < 62) begin
               if (held_keys.size() > 0 && $urandom_range(0, 2) != 0) begin
                  idx = $urandom_range(0, held_keys.size() - 1);
                  v = held_keys[idx];
                  held_keys.delete(idx);
               end else begin
                  v = pick_key();
               end
               push_cmd(MODE_REMOVE, v);
            end else if (r < 95) begin
               if (held_keys.size() > 0 && $urandom_range(0, 2) == 0) begin
                  v = ~held_keys[$urandom_range(0, held_keys.size() - 1)];
               end else begin
                  v = pick_key();
               end
               push_cmd(MODE_QUERY, v);
            end else begin
               push_cmd(MODE_NOP, rand_key());
            end
         end
         wait_for_drain();
      end

      idling_on = 1'b0;
      if (held_keys.size() > 0) begin
         v = held_keys[0];
         push_cmd(MODE_INSERT, v);
         push_cmd(MODE_QUERY, ~v);
         push_cmd(MODE_REMOVE, v);
         push_cmd(MODE_REMOVE, v);
         push_cmd(MODE_INSERT, v);
      end
      for (n = 0; n < 6; n++) begin
         push_cmd(MODE_INSERT, rand_key());
         push_cmd(MODE_QUERY, rand_key());
         push_cmd(MODE_REMOVE, rand_key());
      end
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### binary_trie_max_xor.f
+incdir+sv
sv/btmx_pkg.sv
sv/btmx_ram.sv
sv/btmx_digits.sv
sv/btmx_walk.sv
sv/binary_trie_max_xor.sv
sv/btmx_check.sv
test/binary_trie_max_xor_tb.sv
